>>> sv/rgbc_pkg.sv
// ----------------------------------------------------------------------------
// rgbc_pkg
// Types, constants and helpers shared by the RGB image convolution block.
// ----------------------------------------------------------------------------
package rgbc_pkg;

	localparam int MAX_WIDTH_DEF            = 1024;
	localparam int MAX_KERNEL_SIDE_DEF      = 5;
	localparam int COEFF_BITS_DEF           = 8;
	localparam int FACTOR_FRACTION_BITS_DEF = 16;

	// Jobs that the front may queue ahead of the convolution engine.
	localparam int JOBQ_DEPTH = 2;
	// Line slot index; holds up to sixteen stored lines.
	localparam int SLOT_W     = 4;
	// Distance between written and emitted pixels, at most c*w+c+1.
	localparam int DIST_W     = 14;
	localparam int FACTOR_W   = 24;
	localparam int COEFF_LAST = 24;

	localparam logic       OP_PIXEL     = 1'b0;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] CHAN_MAX     = 8'hFF;

	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_KERNEL_DIM   = 3'd2;
	localparam logic [2:0] REG_FACTOR       = 3'd3;
	localparam logic [2:0] REG_COEFFS_A     = 3'd4;
	localparam logic [2:0] REG_COEFFS_B     = 3'd5;
	localparam logic [2:0] REG_COEFFS_C     = 3'd6;
	localparam logic [2:0] REG_COEFFS_D     = 3'd7;

	typedef struct packed {
		logic       opcode;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_word_t;

	typedef struct packed {
		logic [9:0]  out_column;
		logic [15:0] out_row;
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic [7:0]  out_alpha;
		logic        last_of_image;
	} out_word_t;

	// Effective geometry and coefficients as the datapath sees them.
	typedef struct packed {
		logic [10:0]         w;
		logic [15:0]         h;
		logic [2:0]          k;
		logic [FACTOR_W-1:0] factor;
		logic [199:0]        coeffs;
	} cfg_t;

	typedef struct packed {
		logic [10:0]       col;
		logic [15:0]       row;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} job_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [10:0]       col;
		logic [23:0]       data;
	} mem_wr_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_TAPS,
		B_WAIT,
		B_SCALE,
		B_HOLD
	} back_state_t;

	// Coefficient idx, sign-extended from its low cb bits; zero past the last one.
	function automatic logic signed [7:0] coeff_at(input logic [199:0] raw,
			input logic [7:0] idx, input int cb);
		logic [255:0]       padded;
		logic [7:0]         b;
		logic signed [7:0]  v;
		padded = {56'd0, raw};
		b = padded[{idx[4:0], 3'b000} +: 8];
		for (int i = 0; i < 8; i++) begin
			v[i] = (i < cb) ? b[i] : b[cb-1];
		end
		if (idx > 8'(COEFF_LAST)) begin
			v = '0;
		end
		return v;
	endfunction

endpackage

>>> sv/rgb_image_convolution.sv
// ----------------------------------------------------------------------------
// rgb_image_convolution
// Streaming zero-padded 2D convolution of RGB pixels with up to a 5x5 kernel.
// ----------------------------------------------------------------------------
// Input words are taken one per cycle while the job queue (two jobs) has room.
// The engine takes a due pixel's job from the queue, walks one tap per cycle
// over the single line store read port, then scales the three channels on one
// multiplier; it takes its next job only after the result word is popped.
// Reset clears all control state and restores the register defaults; the line
// store is not cleared, since only entries written in the same frame are read.
module rgb_image_convolution #(
	parameter int MAX_WIDTH            = rgbc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_KERNEL_SIDE      = rgbc_pkg::MAX_KERNEL_SIDE_DEF,
	parameter int COEFF_BITS           = rgbc_pkg::COEFF_BITS_DEF,
	parameter int FACTOR_FRACTION_BITS = rgbc_pkg::FACTOR_FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	input  logic                push,
	output logic                full,
	input  rgbc_pkg::in_word_t  pixel,
	input  logic                pop,
	output logic                empty,
	output rgbc_pkg::out_word_t result
);

	import rgbc_pkg::*;

	localparam int STORE_LINES = MAX_KERNEL_SIDE + JOBQ_DEPTH + 3;
	localparam int CW          = $clog2(MAX_WIDTH);
	localparam int RAM_DEPTH   = STORE_LINES << CW;
	localparam int AW          = $clog2(RAM_DEPTH);

	logic [10:0]  width_q;
	logic [15:0]  height_q;
	logic [2:0]   dim_q;
	logic [23:0]  factor_q;
	logic [63:0]  coeffs_a_q, coeffs_b_q, coeffs_c_q;
	logic [7:0]   coeffs_d_q;

	logic [2:0]   reg_idx;
	logic         reg_wr, restart;
	logic [2:0]   dim_clip;
	cfg_t         cfg;

	logic         q_push, q_full, q_pop, q_empty;
	job_t         q_din, q_dout;
	mem_wr_t      wr;
	logic [SLOT_W-1:0] rd_slot;
	logic [10:0]  rd_col;
	logic [23:0]  rd_data;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign reg_wr  = psel && penable && pwrite && pready;
	assign restart = reg_wr && (reg_idx == REG_IMAGE_WIDTH || reg_idx == REG_IMAGE_HEIGHT ||
		reg_idx == REG_KERNEL_DIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 11'd1024;
			height_q   <= 16'd1;
			dim_q      <= 3'd1;
			factor_q   <= 24'd65536;
			coeffs_a_q <= 64'd1;
			coeffs_b_q <= '0;
			coeffs_c_q <= '0;
			coeffs_d_q <= '0;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_IMAGE_WIDTH:  width_q    <= pwdata[10:0];
				REG_IMAGE_HEIGHT: height_q   <= pwdata[15:0];
				REG_KERNEL_DIM:   dim_q      <= pwdata[2:0];
				REG_FACTOR:       factor_q   <= pwdata[23:0];
				REG_COEFFS_A:     coeffs_a_q <= pwdata;
				REG_COEFFS_B:     coeffs_b_q <= pwdata;
				REG_COEFFS_C:     coeffs_c_q <= pwdata;
				REG_COEFFS_D:     coeffs_d_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IMAGE_WIDTH:  prdata = 64'(width_q);
			REG_IMAGE_HEIGHT: prdata = 64'(height_q);
			REG_KERNEL_DIM:   prdata = 64'(dim_q);
			REG_FACTOR:       prdata = 64'(factor_q);
			REG_COEFFS_A:     prdata = coeffs_a_q;
			REG_COEFFS_B:     prdata = coeffs_b_q;
			REG_COEFFS_C:     prdata = coeffs_c_q;
			REG_COEFFS_D:     prdata = 64'(coeffs_d_q);
			default:          prdata = '0;
		endcase
	end

	// Out-of-range geometry is folded into the legal range; even sides round down.
	always_comb begin
		if (width_q == '0) begin
			cfg.w = 11'd1;
		end else if (32'(width_q) > MAX_WIDTH) begin
			cfg.w = 11'(MAX_WIDTH);
		end else begin
			cfg.w = width_q;
		end
		cfg.h = (height_q == '0) ? 16'd1 : height_q;
		if (dim_q == '0) begin
			dim_clip = 3'd1;
		end else if (32'(dim_q) > MAX_KERNEL_SIDE) begin
			dim_clip = 3'(MAX_KERNEL_SIDE);
		end else begin
			dim_clip = dim_q;
		end
		cfg.k      = (dim_clip - 3'd1) | 3'd1;
		cfg.factor = factor_q;
		cfg.coeffs = {coeffs_d_q, coeffs_c_q, coeffs_b_q, coeffs_a_q};
	end

	rgbc_front #(
		.STORE_LINES(STORE_LINES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.restart    (restart),
		.push       (push),
		.full       (full),
		.pixel      (pixel),
		.queue_full (q_full),
		.job_push   (q_push),
		.job        (q_din),
		.wr         (wr)
	);

	rgbc_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.dout   (q_dout)
	);

	rgbc_ram #(
		.WIDTH(24),
		.DEPTH(RAM_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (wr.en),
		.waddr (AW'({wr.slot, CW'(wr.col)})),
		.wdata (wr.data),
		.raddr (AW'({rd_slot, CW'(rd_col)})),
		.rdata (rd_data)
	);

	rgbc_back #(
		.MAX_KERNEL_SIDE      (MAX_KERNEL_SIDE),
		.COEFF_BITS           (COEFF_BITS),
		.FACTOR_FRACTION_BITS (FACTOR_FRACTION_BITS),
		.STORE_LINES          (STORE_LINES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job_valid (!q_empty),
		.job       (q_dout),
		.job_pop   (q_pop),
		.rd_slot   (rd_slot),
		.rd_col    (rd_col),
		.rd_data   (rd_data),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

>>> sv/rgbc_ram.sv
// ----------------------------------------------------------------------------
// rgbc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rgbc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/rgbc_front.sv
// ----------------------------------------------------------------------------
// rgbc_front
// Accepts pixel and flush words, writes the line store and decides when an
// output pixel is due; due pixels leave as jobs for the convolution engine.
// ----------------------------------------------------------------------------
module rgbc_front #(
	parameter int STORE_LINES = rgbc_pkg::MAX_KERNEL_SIDE_DEF + rgbc_pkg::JOBQ_DEPTH + 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rgbc_pkg::cfg_t     cfg,
	input  logic               restart,
	input  logic               push,
	output logic               full,
	input  rgbc_pkg::in_word_t pixel,
	input  logic               queue_full,
	output logic               job_push,
	output rgbc_pkg::job_t     job,
	output rgbc_pkg::mem_wr_t  wr
);

	import rgbc_pkg::*;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		slot_inc = (s == SLOT_W'(STORE_LINES - 1)) ? '0 : s + 1'b1;
	endfunction

	logic [10:0]       in_col_q, emit_col_q;
	logic [15:0]       in_row_q, emit_row_q;
	logic [SLOT_W-1:0] in_slot_q, emit_slot_q;
	logic [DIST_W-1:0] dist_q;

	logic [1:0]        half;
	logic [DIST_W-1:0] lag;
	logic              accept, in_done, wr_en, done_n, emit, last;
	logic [10:0]       col_n;
	logic [15:0]       row_n;
	logic [SLOT_W-1:0] slot_n;
	logic [DIST_W-1:0] dist_n;

	assign half   = cfg.k[2:1];
	assign lag    = DIST_W'(half) * DIST_W'(cfg.w) + DIST_W'(half);
	assign accept = push && !queue_full;
	assign full   = queue_full;
	assign in_done = (in_row_q == cfg.h);
	assign wr_en  = accept && (pixel.opcode == OP_PIXEL) && !in_done;

	always_comb begin
		col_n  = in_col_q;
		row_n  = in_row_q;
		slot_n = in_slot_q;
		dist_n = dist_q;
		if (wr_en) begin
			dist_n = dist_q + 1'b1;
			if (in_col_q == cfg.w - 11'd1) begin
				col_n  = '0;
				row_n  = in_row_q + 16'd1;
				slot_n = slot_inc(in_slot_q);
			end else begin
				col_n = in_col_q + 11'd1;
			end
		end
	end

	// The window is complete once c rows and c pixels beyond it are in.
	assign done_n = (row_n == cfg.h);
	assign emit   = accept && (emit_row_q < cfg.h) && ((dist_n > lag) || done_n);
	assign last   = (emit_row_q == cfg.h - 16'd1) && (emit_col_q == cfg.w - 11'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			emit_col_q  <= '0;
			emit_row_q  <= '0;
			emit_slot_q <= '0;
			dist_q      <= '0;
		end else if (restart) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			emit_col_q  <= '0;
			emit_row_q  <= '0;
			emit_slot_q <= '0;
			dist_q      <= '0;
		end else if (accept) begin
			if (emit && last) begin
				// The next frame starts in the slot after the last row received.
				in_col_q    <= '0;
				in_row_q    <= '0;
				in_slot_q   <= slot_n;
				emit_col_q  <= '0;
				emit_row_q  <= '0;
				emit_slot_q <= slot_n;
				dist_q      <= '0;
			end else begin
				in_col_q  <= col_n;
				in_row_q  <= row_n;
				in_slot_q <= slot_n;
				dist_q    <= dist_n - DIST_W'(emit);
				if (emit) begin
					if (emit_col_q == cfg.w - 11'd1) begin
						emit_col_q  <= '0;
						emit_row_q  <= emit_row_q + 16'd1;
						emit_slot_q <= slot_inc(emit_slot_q);
					end else begin
						emit_col_q <= emit_col_q + 11'd1;
					end
				end
			end
		end
	end

	assign job_push = emit;
	assign job.col  = emit_col_q;
	assign job.row  = emit_row_q;
	assign job.slot = emit_slot_q;
	assign job.last = last;

	assign wr.en   = wr_en;
	assign wr.slot = in_slot_q;
	assign wr.col  = in_col_q;
	assign wr.data = {pixel.in_red, pixel.in_green, pixel.in_blue};

	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dist_q <= lag + DIST_W'(1))
		else $error("front runs further ahead of the emit position than the window needs");

endmodule

>>> sv/rgbc_jobq.sv
// ----------------------------------------------------------------------------
// rgbc_jobq
// Short job queue between the front and the convolution engine.
// ----------------------------------------------------------------------------
module rgbc_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rgbc_pkg::job_t din,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output rgbc_pkg::job_t dout
);

	import rgbc_pkg::*;

	localparam int PW = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;

	job_t        mem_q [JOBQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(JOBQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full  = (count_q == (PW+1)'(JOBQ_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("job written into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("job taken from an empty queue");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(JOBQ_DEPTH))
		else $error("job queue count out of range");

endmodule

>>> sv/rgbc_back.sv
// ----------------------------------------------------------------------------
// rgbc_back
// Convolution engine: walks the k x k window one tap per cycle through the
// line store, accumulates three channel sums, then scales and clamps them.
// ----------------------------------------------------------------------------
module rgbc_back #(
	parameter int MAX_KERNEL_SIDE      = rgbc_pkg::MAX_KERNEL_SIDE_DEF,
	parameter int COEFF_BITS           = rgbc_pkg::COEFF_BITS_DEF,
	parameter int FACTOR_FRACTION_BITS = rgbc_pkg::FACTOR_FRACTION_BITS_DEF,
	parameter int STORE_LINES          = rgbc_pkg::MAX_KERNEL_SIDE_DEF + rgbc_pkg::JOBQ_DEPTH + 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rgbc_pkg::cfg_t              cfg,
	input  logic                        job_valid,
	input  rgbc_pkg::job_t              job,
	output logic                        job_pop,
	output logic [rgbc_pkg::SLOT_W-1:0] rd_slot,
	output logic [10:0]                 rd_col,
	input  logic [23:0]                 rd_data,
	output logic                        empty,
	input  logic                        pop,
	output rgbc_pkg::out_word_t         result
);

	import rgbc_pkg::*;

	localparam int CB    = (COEFF_BITS > 8) ? 8 : COEFF_BITS;
	localparam int KW    = $clog2(MAX_KERNEL_SIDE);
	localparam int CIW   = $clog2(MAX_KERNEL_SIDE * MAX_KERNEL_SIDE);
	localparam int SUM_W = CB + 9 + $clog2(MAX_KERNEL_SIDE * MAX_KERNEL_SIDE);
	localparam int PW    = SUM_W - 1 + FACTOR_W;
	localparam int TW    = $clog2(3 * STORE_LINES);

	back_state_t state_q, state_d;
	job_t        job_q;
	logic [KW-1:0]  ky_q, kx_q;
	logic [CIW-1:0] ci_q;
	logic signed [SUM_W-1:0] acc_q [3];
	logic               tap_s1, ok_s1;
	logic signed [7:0]  coef_s1;
	logic [1:0]         ch_q;
	logic [PW-1:0]      prod_s2;
	logic [7:0]         res_q [3];

	logic [1:0]         half;
	logic               tap_end, in_taps, ok;
	logic [17:0]        yy;
	logic [12:0]        xx;
	logic [TW-1:0]      slot_t, slot_w;
	logic signed [7:0]  coef;
	logic signed [SUM_W-1:0] acc_sel;
	logic [SUM_W-2:0]   mag;
	logic [PW-1:0]      shifted;
	logic [7:0]         clamped;
	logic [23:0]        pix;
	logic [5:0]         kk;

	assign half    = cfg.k[2:1];
	assign tap_end = (ky_q == KW'(cfg.k - 3'd1)) && (kx_q == KW'(cfg.k - 3'd1));
	assign kk      = {3'b0, cfg.k} * {3'b0, cfg.k} - 6'd1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:  if (job_valid) state_d = B_TAPS;
			B_TAPS:  if (tap_end) state_d = B_WAIT;
			B_WAIT:  state_d = B_SCALE;
			B_SCALE: if (ch_q == 2'd3) state_d = B_HOLD;
			B_HOLD:  if (pop) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		job_pop = (state_q == B_IDLE) && job_valid;
		empty   = (state_q != B_HOLD);
		in_taps = (state_q == B_TAPS);
	end

	// Window position of the current tap and its slot in the line store.
	always_comb begin
		yy = 18'(job_q.row) + 18'(ky_q) - 18'(half);
		xx = 13'(job_q.col) + 13'(kx_q) - 13'(half);
		ok = !yy[17] && (yy[16:0] < {1'b0, cfg.h}) && !xx[12] && (xx[11:0] < {1'b0, cfg.w});
		slot_t = TW'(job_q.slot) + TW'(STORE_LINES) + TW'(ky_q) - TW'(half);
		if (slot_t >= TW'(2 * STORE_LINES)) begin
			slot_w = slot_t - TW'(2 * STORE_LINES);
		end else if (slot_t >= TW'(STORE_LINES)) begin
			slot_w = slot_t - TW'(STORE_LINES);
		end else begin
			slot_w = slot_t;
		end
		rd_slot = SLOT_W'(slot_w);
		rd_col  = xx[10:0];
		coef    = coeff_at(cfg.coeffs, 8'(ci_q), CB);
	end

	always_comb begin
		case (ch_q)
			2'd0:    acc_sel = acc_q[0];
			2'd1:    acc_sel = acc_q[1];
			default: acc_sel = acc_q[2];
		endcase
		mag     = (acc_sel > 0) ? acc_sel[SUM_W-2:0] : '0;
		shifted = prod_s2 >> FACTOR_FRACTION_BITS;
		clamped = (|shifted[PW-1:8]) ? CHAN_MAX : shifted[7:0];
	end

	assign pix = rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			tap_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			tap_s1  <= in_taps;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1   <= ok;
		coef_s1 <= coef;
		if (job_pop) begin
			job_q <= job;
			ky_q  <= '0;
			kx_q  <= '0;
			ci_q  <= CIW'(kk);
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
			end
		end
		if (in_taps) begin
			ci_q <= ci_q - 1'b1;
			if (kx_q == KW'(cfg.k - 3'd1)) begin
				kx_q <= '0;
				ky_q <= ky_q + 1'b1;
			end else begin
				kx_q <= kx_q + 1'b1;
			end
		end
		if (tap_s1 && ok_s1) begin
			acc_q[0] <= acc_q[0] + SUM_W'($signed({1'b0, pix[23:16]}) * coef_s1);
			acc_q[1] <= acc_q[1] + SUM_W'($signed({1'b0, pix[15:8]}) * coef_s1);
			acc_q[2] <= acc_q[2] + SUM_W'($signed({1'b0, pix[7:0]}) * coef_s1);
		end
		if (state_q == B_WAIT) begin
			ch_q <= '0;
		end
		// One shared multiplier: channel n is scaled while channel n-1 is clamped.
		if (state_q == B_SCALE) begin
			ch_q <= ch_q + 2'd1;
			if (ch_q != 2'd3) begin
				prod_s2 <= PW'(mag) * PW'(cfg.factor);
			end
			case (ch_q)
				2'd1:    res_q[0] <= clamped;
				2'd2:    res_q[1] <= clamped;
				2'd3:    res_q[2] <= clamped;
				default: ;
			endcase
		end
	end

	assign result.out_column    = job_q.col[9:0];
	assign result.out_row       = job_q.row;
	assign result.out_red       = res_q[0];
	assign result.out_green     = res_q[1];
	assign result.out_blue      = res_q[2];
	assign result.out_alpha     = ALPHA_OPAQUE;
	assign result.last_of_image = job_q.last;

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_HOLD && pop) |=> state_q == B_IDLE)
		else $error("engine kept a word that was taken");
	a_job_starts: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> state_q == B_TAPS)
		else $error("job taken without starting the window walk");
	a_tap_window: assert property (@(posedge clk) disable iff (!arst_n)
		tap_s1 |-> (state_q == B_TAPS || state_q == B_WAIT))
		else $error("tap data arrived outside the window walk");

endmodule
